@@ design/bups_pkg.sv @@
package bups_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 8;
	localparam int ENTRY_W  = 8;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [CFG_W-1:0] CAP_RESET = 8'd100;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                success;
	} res_t;

endpackage

@@ design/bups_ifs.sv @@
interface bups_req_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, op, point_x, point_y, input ready);
	modport sink (input valid, op, point_x, point_y, output ready);
endinterface

interface bups_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       success;
	logic [7:0] entry_count;

	modport source (output valid, status, success, entry_count, input ready);
	modport sink (input valid, status, success, entry_count, output ready);
endinterface

interface bups_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] capacity_limit;

	modport source (output valid, capacity_limit, input ready);
	modport sink (input valid, capacity_limit, output ready);
endinterface

@@ design/bups_ram.sv @@
module bups_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/bups_seq.sv @@
module bups_seq import bups_pkg::*; #(
	parameter int CAPACITY   = 128,
	parameter int COORD_BITS = 16,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [OP_W-1:0]       req_op,
	input  logic [COORD_BITS-1:0] req_x,
	input  logic [COORD_BITS-1:0] req_y,
	input  logic [CFG_W-1:0]      cap_limit,
	output logic                  res_valid,
	input  logic                  res_take,
	output res_t                  res,
	output logic [CW-1:0]         count
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KW = 2 * COORD_BITS;
	localparam int MW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SRCH  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_RESP  = 2'd3;

	logic [1:0]      state_q;
	logic [OP_W-1:0] op_q;
	logic [KW-1:0]   key_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_q;
	logic            cmp_v_s1;
	logic [CW-1:0]   cmp_idx_s1;
	logic            sh_pend_s1;
	logic [AW-1:0]   sh_wr_s1;
	res_t            res_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [KW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [KW-1:0]   ram_rdata;

	logic            hit;
	logic            not_found;
	logic            more;
	logic            full;
	logic            accept;

	bups_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The set is full when the count reaches the smaller of the register and the depth.
	assign full = (MW'(count_q) >= MW'(cap_limit)) || (count_q >= CW'(CAPACITY));
	assign accept = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res = res_q;
	assign count = count_q;

	assign more = (rd_q < count_q);
	assign hit = cmp_v_s1 && (ram_rdata == key_q);
	// A miss on the last stored entry, or an empty set, ends the search.
	assign not_found = cmp_v_s1 ? (CW'(cmp_idx_s1 + 1'b1) == count_q) : !more;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = sh_wr_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			S_SRCH: begin
				if (!hit && !not_found && more) begin
					ram_re = 1'b1;
				end
				if (!hit && not_found && op_q == OP_INSERT) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = key_q;
				end
			end
			S_SHIFT: begin
				ram_re = more;
				ram_we = sh_pend_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			cmp_v_s1   <= 1'b0;
			sh_pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req_op;
						key_q    <= {req_x, req_y};
						rd_q     <= '0;
						cmp_v_s1 <= 1'b0;
						case (req_op)
							OP_LOOKUP, OP_REMOVE: begin
								state_q <= S_SRCH;
							end
							OP_INSERT: begin
								if (full) begin
									res_q   <= '{status: ST_FULL, success: 1'b0};
									state_q <= S_RESP;
								end else begin
									state_q <= S_SRCH;
								end
							end
							default: begin
								res_q   <= '{status: ST_DONE, success: 1'b0};
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (hit) begin
						cmp_v_s1 <= 1'b0;
						case (op_q)
							OP_INSERT: begin
								res_q   <= '{status: ST_PRESENT, success: 1'b0};
								state_q <= S_RESP;
							end
							OP_REMOVE: begin
								rd_q       <= CW'(cmp_idx_s1 + 1'b1);
								sh_pend_s1 <= 1'b0;
								state_q    <= S_SHIFT;
							end
							default: begin
								res_q   <= '{status: ST_DONE, success: 1'b1};
								state_q <= S_RESP;
							end
						endcase
					end else if (not_found) begin
						cmp_v_s1 <= 1'b0;
						state_q  <= S_RESP;
						if (op_q == OP_INSERT) begin
							count_q <= CW'(count_q + 1'b1);
							res_q   <= '{status: ST_DONE, success: 1'b1};
						end else begin
							res_q <= '{status: ST_NOT_FOUND, success: 1'b0};
						end
					end else begin
						cmp_v_s1   <= ram_re;
						cmp_idx_s1 <= rd_q;
						if (ram_re) begin
							rd_q <= CW'(rd_q + 1'b1);
						end
					end
				end
				S_SHIFT: begin
					// Each entry read here is written one place lower in the following cycle.
					if (more) begin
						sh_pend_s1 <= 1'b1;
						sh_wr_s1   <= AW'(rd_q - 1'b1);
						rd_q       <= CW'(rd_q + 1'b1);
					end else begin
						sh_pend_s1 <= 1'b0;
						if (!sh_pend_s1) begin
							count_q <= CW'(count_q - 1'b1);
							res_q   <= '{status: ST_DONE, success: 1'b1};
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/bounded_unique_point_set_top.sv @@
// Channel  Dir  Transaction                         Payload
// req      in   one operation on the set            op, point_x, point_y
// rsp      out  one result per operation            status, success, entry_count
// cfg      in   write of capacity_limit             capacity_limit
//
// One operation at a time. A lookup or insert runs a linear search through the point
// memory (one entry a cycle), which ends at a hit or after the last stored entry.
// A remove that hits then runs a shift-down pass that moves each later entry one place lower.
// An insert into a full set or an unknown op is answered without a search.
// Reset empties the set and loads capacity_limit with 100; no clearing pass is run.
// A stalled rsp holds its result, and the next req is taken while it waits.
module bounded_unique_point_set_top import bups_pkg::*; #(
	parameter int CAPACITY   = 128,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bups_req_if.sink    req,
	bups_rsp_if.source  rsp,
	bups_cfg_if.sink    cfg
);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CFG_W-1:0]   cap_q;
	logic               res_valid;
	logic               res_take;
	res_t               res;
	logic [CW-1:0]      count;
	logic               out_v_q;
	res_t               out_q;
	logic [ENTRY_W-1:0] entry_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity_limit;
		end
	end

	bups_seq #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.op),
		.req_x     ($unsigned(req.point_x)),
		.req_y     ($unsigned(req.point_y)),
		.cap_limit (cap_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.count     (count)
	);

	assign res_take = res_valid && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_take) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q         <= res;
			entry_count_q <= ENTRY_W'(count);
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.status      = out_q.status;
	assign rsp.success     = out_q.success;
	assign rsp.entry_count = entry_count_q;

endmodule

@@ design/bups_checker.sv @@
module bups_checker import bups_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic                success,
	input logic [ENTRY_W-1:0]  entry_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(success) &&
		$stable(entry_count))
		else $error("response payload changed while stalled");

	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && success |-> status == ST_DONE)
		else $error("success reported with a failure status");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in progress");

endmodule

bind bounded_unique_point_set_top bups_checker u_bups_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.success     (rsp.success),
	.entry_count (rsp.entry_count)
);

@@ verif/tb_bounded_unique_point_set_top.sv @@
`timescale 1ns / 1ps

module tb_bounded_unique_point_set_top;
	import bups_pkg::*;

	localparam int CAPACITY    = 128;
	localparam int COORD_BITS  = 16;
	localparam int POOL_N      = 160;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 300;

	localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                success;
		logic [ENTRY_W-1:0]  entry_count;
	} outcome_t;

	typedef struct {
		bit                  is_cfg;
		logic [CFG_W-1:0]    cap;
		logic [OP_W-1:0]     op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		bit                  pin;
		outcome_t            want;
	} step_t;

	typedef struct {
		logic [CFG_W-1:0] cap;
		int               n;
		int               span;
		int               ins_pct;
		int               rem_pct;
		bit               fresh;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	bups_req_if #(.COORD_BITS(COORD_BITS)) req_ch();
	bups_rsp_if rsp_ch();
	bups_cfg_if cfg_ch();

	bounded_unique_point_set_top #(
		.CAPACITY(CAPACITY),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the set, kept in step with accepted transactions.
	logic [COORD_BITS-1:0] set_x [CAPACITY];
	logic [COORD_BITS-1:0] set_y [CAPACITY];
	int                    set_count = 0;
	logic [CFG_W-1:0]      cap_limit = CAP_RESET;

	outcome_t awaited_results [$];

	int       err_count = 0;
	int       ops_sent = 0;
	int       results_seen = 0;
	int       cap_writes = 0;
	int       peak_count = 0;
	int       full_refusals = 0;
	int       dup_refusals = 0;
	int       stall_cycles = 0;
	int       send_idle = 25;
	int       recv_idle = 53;
	bit       timed_out = 1'b0;
	bit       pin_now = 1'b0;
	outcome_t pin_want = '0;

	logic [COORD_BITS-1:0] pool_x [POOL_N];
	logic [COORD_BITS-1:0] pool_y [POOL_N];

	step_t dir_rows [27] = '{
		'{1'b0, 8'd0, OP_LOOKUP,  16'h0000, 16'h0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 8'd0}},
		'{1'b0, 8'd0, OP_REMOVE,  16'h0000, 16'h0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 8'd0}},
		'{1'b0, 8'd0, OP_UNKNOWN, 16'h0000, 16'h0000, 1'b1, '{ST_DONE,      1'b0, 8'd0}},
		'{1'b0, 8'd0, OP_INSERT,  16'h8000, 16'h7FFF, 1'b1, '{ST_DONE,      1'b1, 8'd1}},
		'{1'b0, 8'd0, OP_INSERT,  16'h8000, 16'h7FFF, 1'b1, '{ST_PRESENT,   1'b0, 8'd1}},
		'{1'b0, 8'd0, OP_LOOKUP,  16'h8000, 16'h7FFF, 1'b1, '{ST_DONE,      1'b1, 8'd1}},
		'{1'b0, 8'd0, OP_LOOKUP,  16'h7FFF, 16'h8000, 1'b1, '{ST_NOT_FOUND, 1'b0, 8'd1}},
		'{1'b0, 8'd0, OP_INSERT,  16'h7FFF, 16'h8000, 1'b1, '{ST_DONE,      1'b1, 8'd2}},
		'{1'b0, 8'd0, OP_INSERT,  16'h0000, 16'h0000, 1'b1, '{ST_DONE,      1'b1, 8'd3}},
		'{1'b0, 8'd0, OP_INSERT,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,      1'b1, 8'd4}},
		'{1'b0, 8'd0, OP_INSERT,  16'hFFFF, 16'h0000, 1'b1, '{ST_DONE,      1'b1, 8'd5}},
		'{1'b0, 8'd0, OP_INSERT,  16'h5555, 16'hAAAA, 1'b1, '{ST_DONE,      1'b1, 8'd6}},
		'{1'b0, 8'd0, OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,      1'b0, 8'd6}},
		'{1'b0, 8'd0, OP_REMOVE,  16'h7FFF, 16'h8000, 1'b0, '0},
		'{1'b0, 8'd0, OP_LOOKUP,  16'h7FFF, 16'h8000, 1'b0, '0},
		'{1'b0, 8'd0, OP_LOOKUP,  16'hFFFF, 16'h0000, 1'b0, '0},
		'{1'b0, 8'd0, OP_REMOVE,  16'h5555, 16'hAAAA, 1'b0, '0},
		'{1'b0, 8'd0, OP_REMOVE,  16'h8000, 16'h7FFF, 1'b0, '0},
		'{1'b0, 8'd0, OP_REMOVE,  16'hFFFF, 16'h0000, 1'b0, '0},
		'{1'b1, 8'd1, OP_LOOKUP,  16'h0000, 16'h0000, 1'b0, '0},
		'{1'b0, 8'd0, OP_INSERT,  16'h0000, 16'h0000, 1'b1, '{ST_FULL,      1'b0, 8'd2}},
		'{1'b0, 8'd0, OP_INSERT,  16'hAAAA, 16'h5555, 1'b1, '{ST_FULL,      1'b0, 8'd2}},
		'{1'b1, 8'd0, OP_LOOKUP,  16'h0000, 16'h0000, 1'b0, '0},
		'{1'b0, 8'd0, OP_REMOVE,  16'h0000, 16'h0000, 1'b1, '{ST_DONE,      1'b1, 8'd1}},
		'{1'b0, 8'd0, OP_INSERT,  16'hAAAA, 16'h5555, 1'b1, '{ST_FULL,      1'b0, 8'd1}},
		'{1'b0, 8'd0, OP_REMOVE,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,      1'b1, 8'd0}},
		'{1'b0, 8'd0, OP_INSERT,  16'h0001, 16'h0001, 1'b1, '{ST_FULL,      1'b0, 8'd0}}
	};

	// Small pools make hits likely; a pool kept across a phase lets removes
	// find the entries left behind when the capacity is lowered below the count.
	phase_t phases [9] = '{
		'{8'd255, 250, 150, 60, 15, 1'b1},
		'{8'd4,    80,   8, 40, 30, 1'b1},
		'{8'd1,    50,   3, 40, 30, 1'b1},
		'{8'd128, 220, 140, 60, 12, 1'b1},
		'{8'd10,  100, 140, 10, 60, 1'b0},
		'{8'd0,    60, 140, 40, 30, 1'b0},
		'{8'd100, 120, 110, 55, 20, 1'b1},
		'{8'd2,    60,   4, 40, 30, 1'b1},
		'{8'd64,   80,  72, 50, 25, 1'b1}
	};

	function automatic int find_entry(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
		for (int i = 0; i < set_count; i++)
			if (set_x[i] == x && set_y[i] == y)
				return i;
		return set_count;
	endfunction

	function automatic outcome_t apply_set_op(logic [OP_W-1:0] op,
			logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
		int       pos;
		int       lim;
		outcome_t o;
		o = '0;
		o.status = ST_DONE;
		lim = int'(cap_limit);
		if (lim > CAPACITY)
			lim = CAPACITY;
		pos = find_entry(x, y);
		case (op)
			OP_LOOKUP: begin
				if (pos < set_count)
					o.success = 1'b1;
				else
					o.status = ST_NOT_FOUND;
			end
			OP_INSERT: begin
				// Fullness wins over presence.
				if (set_count >= lim) begin
					o.status = ST_FULL;
				end else if (pos < set_count) begin
					o.status = ST_PRESENT;
				end else begin
					set_x[set_count] = x;
					set_y[set_count] = y;
					set_count++;
					o.success = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos < set_count) begin
					for (int j = pos; j + 1 < set_count; j++) begin
						set_x[j] = set_x[j + 1];
						set_y[j] = set_y[j + 1];
					end
					set_count--;
					o.success = 1'b1;
				end else begin
					o.status = ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
		o.entry_count = set_count[ENTRY_W-1:0];
		return o;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				cap_limit = cfg_ch.capacity_limit;
				cap_writes++;
			end
			if (req_ch.valid && req_ch.ready) begin
				want = apply_set_op(req_ch.op, req_ch.point_x, req_ch.point_y);
				if (pin_now)
					want = pin_want;
				if (want.status == ST_FULL)
					full_refusals++;
				if (want.status == ST_PRESENT)
					dup_refusals++;
				if (set_count > peak_count)
					peak_count = set_count;
				awaited_results.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.status, rsp_ch.success, rsp_ch.entry_count};
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result with no operation outstanding: status %0d success %0d count %0d",
						got.status, got.success, got.entry_count);
					err_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, got.status);
						err_count++;
					end
					if (got.success !== want.success) begin
						$error("success mismatch: expected %0d, got %0d", want.success, got.success);
						err_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count mismatch: expected %0d, got %0d",
							want.entry_count, got.entry_count);
						err_count++;
					end
				end
			end
		end
	end

	// Lowers the request and waits until every outstanding result has come back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic write_cap(input logic [CFG_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity_limit <= v;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic push_op(input logic [OP_W-1:0] op, input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y, input bit pin, input outcome_t want);
		if (ops_sent < 350) begin
			send_idle = 25;
			recv_idle = 53;
		end else if (ops_sent < 700) begin
			send_idle = 53;
			recv_idle = 25;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.point_x <= x;
		req_ch.point_y <= y;
		pin_now <= pin;
		pin_want <= want;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		ops_sent++;
	endtask

	initial begin
		int                    r;
		int                    idx;
		logic [OP_W-1:0]       op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_LOOKUP;
		req_ch.point_x = '0;
		req_ch.point_y = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.capacity_limit = '0;

		fork
			begin
				repeat (8) @(posedge clk);
				arst_n <= 1'b1;

				foreach (dir_rows[i]) begin
					if (dir_rows[i].is_cfg) begin
						settle();
						write_cap(dir_rows[i].cap);
					end else begin
						push_op(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y,
							dir_rows[i].pin, dir_rows[i].want);
					end
				end

				foreach (phases[p]) begin
					settle();
					write_cap(phases[p].cap);
					if (phases[p].fresh)
						for (int i = 0; i < POOL_N; i++) begin
							pool_x[i] = pick_coord();
							pool_y[i] = pick_coord();
						end
					for (int k = 0; k < phases[p].n; k++) begin
						r = $urandom_range(99);
						if (r < 3)
							op = OP_UNKNOWN;
						else if (r < 3 + phases[p].ins_pct)
							op = OP_INSERT;
						else if (r < 3 + phases[p].ins_pct + phases[p].rem_pct)
							op = OP_REMOVE;
						else
							op = OP_LOOKUP;
						idx = $urandom_range(phases[p].span - 1);
						x = pool_x[idx];
						y = pool_y[idx];
						// A few near misses and fully random points.
						r = $urandom_range(99);
						if (r < 4)
							y = COORD_BITS'($urandom);
						else if (r < 8) begin
							x = COORD_BITS'($urandom);
							y = COORD_BITS'($urandom);
						end
						push_op(op, x, y, 1'b0, '0);
					end
				end

				settle();
				repeat (TAIL_CYCLES) @(posedge clk);
				if (awaited_results.size() != 0) begin
					$error("%0d results never arrived", awaited_results.size());
					err_count += awaited_results.size();
				end
			end
			begin
				wait (stall_cycles >= STALL_LIMIT);
				timed_out = 1'b1;
			end
		join_any

		$display("Covered %0d operations and %0d results over %0d capacity writes, %s.",
			ops_sent, results_seen, cap_writes,
			timed_out ? "stopped by the stall watchdog" : "all drained");
		$display("Peak occupancy %0d entries; %0d full-set and %0d duplicate refusals.",
			peak_count, full_refusals, dup_refusals);
		if (timed_out || err_count != 0)
			$display("end of test: mismatches");
		else
			$display("end of test: clean");
		$finish;
	end

endmodule

@@ bounded_unique_point_set_top.f @@
design/bups_pkg.sv
design/bups_ifs.sv
design/bups_ram.sv
design/bups_seq.sv
design/bounded_unique_point_set_top.sv
design/bups_checker.sv
verif/tb_bounded_unique_point_set_top.sv
